// ----- hw/rtl/triangle_edge_opposite_vertex_finder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the triangle edge opposite vertex finder
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_EDGE_OPPOSITE_VERTEX_FINDER_MACROS_SVH
`define TRIANGLE_EDGE_OPPOSITE_VERTEX_FINDER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define TEOVF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("teovf: same-cycle check failed");
// Next-cycle implication
`define TEOVF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("teovf: next-cycle check failed");
`else
`define TEOVF_ASSERT_IMP(lbl, ante, cons)
`define TEOVF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/teovf_pkg.sv -----
// ----------------------------------------------------------------------------
// teovf_pkg
// Word types, command codes, state encoding and helpers shared by the
// triangle edge opposite vertex finder.
// ----------------------------------------------------------------------------
`default_nettype none

package teovf_pkg;

  localparam int FACE_IDX_BITS     = 10;
  localparam int FIELD_VERTEX_BITS = 16;
  localparam int FACE_COUNT_BITS   = 11;

  // Command codes of an input word
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [FACE_IDX_BITS-1:0]     face_idx_t;
  typedef logic [FIELD_VERTEX_BITS-1:0] vertex_t;
  typedef logic [FACE_COUNT_BITS-1:0]   cfg_word_t;

  typedef struct packed {
    logic      command;
    face_idx_t face_index;
    vertex_t   vertex_a;
    vertex_t   vertex_b;
    vertex_t   vertex_c;
  } in_word_t;

  typedef struct packed {
    face_idx_t queried_face;
    vertex_t   wing_zero;
    logic      wing_zero_found;
    vertex_t   wing_one;
    logic      wing_one_found;
    vertex_t   wing_two;
    logic      wing_two_found;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic store_wr;
    logic start_query;
    logic load_face;
    logic scan_read;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_is_query;
    logic in_in_range;
    logic scan_done;
    logic out_free;
  } dp_status_t;

  // Corner one step ahead, modulo three
  function automatic logic [1:0] next1(input logic [1:0] c);
    logic [1:0] r;
    unique case (c)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Corner two steps ahead, modulo three
  function automatic logic [1:0] next2(input logic [1:0] c);
    logic [1:0] r;
    unique case (c)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/teovf_if.sv -----
// ----------------------------------------------------------------------------
// teovf channel interfaces
// Valid/ready channels for input words, result words and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface teovf_in_if;
  import teovf_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface teovf_out_if;
  import teovf_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface teovf_cfg_if;
  import teovf_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/triangle_edge_opposite_vertex_finder.sv -----
// ----------------------------------------------------------------------------
// triangle_edge_opposite_vertex_finder: finds wing vertices across face edges
// Store words are taken back to back. A query is taken, its face is read and
// the table is scanned one face per cycle up to face_count (capped at
// MAX_FACES); the result is then raised and the input freed, stalled while
// the output register is full. Synchronous active-low reset clears control
// and face_count; the face table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_edge_opposite_vertex_finder_macros.svh"

module triangle_edge_opposite_vertex_finder #(
  parameter int MAX_FACES   = 1024,
  parameter int VERTEX_BITS = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  teovf_in_if.sink   in_ch,
  teovf_out_if.source out_ch,
  teovf_cfg_if.sink  cfg_ch
);
  import teovf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequencer
  teovf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath with face table
  teovf_dp #(
    .MAX_FACES   (MAX_FACES),
    .VERTEX_BITS (VERTEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cfg_valid (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .cfg_ready (cfg_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Never overwrite a result that still waits
  `TEOVF_ASSERT_IMP(a_finish_out_free, cmd.finish, sts.out_free)
  // Never read past the face count
  `TEOVF_ASSERT_IMP(a_scan_bounded, cmd.scan_read, !sts.scan_done)
  // An accepted query holds off the next word
  `TEOVF_ASSERT_NEXT(a_query_blocks,
                     in_ch.valid && in_ch.ready && in_ch.data.command == CMD_QUERY,
                     !in_ch.ready)

endmodule

`default_nettype wire

// ----- hw/rtl/teovf_ram.sv -----
// ----------------------------------------------------------------------------
// teovf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module teovf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/teovf_ctrl.sv -----
// ----------------------------------------------------------------------------
// teovf_ctrl
// Sequencer: takes words, runs the face table scan of a query and hands
// the finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module teovf_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire teovf_pkg::dp_status_t  sts,
  output teovf_pkg::ctrl_cmd_t        cmd
);
  import teovf_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (sts.in_is_query) begin
            cmd.start_query = 1'b1;
            state_nxt = sts.in_in_range ? ST_FETCH : ST_DONE;
          end else begin
            cmd.store_wr = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd.load_face = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_read = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_read = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/teovf_dp.sv -----
// ----------------------------------------------------------------------------
// teovf_dp
// Face table, scan counter, reversed-edge compare, wing registers,
// face count register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module teovf_dp #(
  parameter int MAX_FACES   = 1024,
  parameter int VERTEX_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire teovf_pkg::in_word_t   in_data,
  input  wire logic                  cfg_valid,
  input  wire teovf_pkg::cfg_word_t  cfg_data,
  output logic                       cfg_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output teovf_pkg::out_word_t       out_data,
  input  wire teovf_pkg::ctrl_cmd_t  cmd,
  output teovf_pkg::dp_status_t      sts
);
  import teovf_pkg::*;

  localparam int AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int CW = $clog2(MAX_FACES + 1);
  localparam int FW = 3 * VERTEX_BITS;

  typedef logic [VERTEX_BITS-1:0] vtx_t;

  cfg_word_t       face_count_r;
  logic [CW-1:0]   n_r, k_r;
  logic            cmp_v_r;
  face_idx_t       qidx_r;
  vtx_t            q_r [3];
  vtx_t            wing_r [3];
  vtx_t            wing_nxt [3];
  logic [2:0]      found_r, found_nxt;
  logic            out_valid_r;
  out_word_t       out_r;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [FW-1:0]   ram_wdata, ram_rdata;
  vtx_t            f [3];
  logic [CW-1:0]   n_nxt;

  // Configuration word: always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_count_r <= '0;
    end else if (cfg_valid) begin
      face_count_r <= cfg_data;
    end
  end

  // Status toward the controller
  assign sts.in_is_query = (in_data.command == CMD_QUERY);
  assign sts.in_in_range = (32'(in_data.face_index) < 32'(MAX_FACES));
  assign sts.scan_done   = (k_r == n_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  // Face table: corner 0 in the low bits
  assign ram_we    = cmd.store_wr && sts.in_in_range;
  assign ram_wdata = {VERTEX_BITS'(in_data.vertex_c), VERTEX_BITS'(in_data.vertex_b),
                      VERTEX_BITS'(in_data.vertex_a)};
  assign ram_re    = cmd.start_query || cmd.scan_read;
  assign ram_raddr = cmd.start_query ? AW'(in_data.face_index) : AW'(k_r);

  teovf_ram #(
    .WIDTH (FW),
    .DEPTH (MAX_FACES),
    .AW    (AW)
  ) u_face_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_data.face_index)),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign f[0] = ram_rdata[VERTEX_BITS-1:0];
  assign f[1] = ram_rdata[2*VERTEX_BITS-1:VERTEX_BITS];
  assign f[2] = ram_rdata[3*VERTEX_BITS-1:2*VERTEX_BITS];

  // Clamp the face count to the table depth
  assign n_nxt = (32'(face_count_r) > 32'(MAX_FACES)) ? CW'(MAX_FACES) : CW'(face_count_r);

  // Scan counter and compare-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r <= 1'b0;
    end else begin
      cmp_v_r <= cmd.scan_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      k_r    <= '0;
      n_r    <= n_nxt;
      qidx_r <= in_data.face_index;
    end else if (cmd.scan_read) begin
      k_r <= k_r + CW'(1);
    end
  end

  // Capture the queried face's corners
  always_ff @(posedge clk) begin
    if (cmd.load_face) begin
      q_r[0] <= f[0];
      q_r[1] <= f[1];
      q_r[2] <= f[2];
    end
  end

  // Look for each query edge reversed in the scanned face; last match wins
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wing_nxt[j] = wing_r[j];
    end
    found_nxt = found_r;
    if (cmd.start_query) begin
      for (int j = 0; j < 3; j++) begin
        wing_nxt[j] = '0;
      end
      found_nxt = '0;
    end else if (cmp_v_r) begin
      for (int j = 0; j < 3; j++) begin
        for (int l = 0; l < 3; l++) begin
          if (f[next1(2'(l))] == q_r[next2(2'(j))] &&
              f[next2(2'(l))] == q_r[next1(2'(j))]) begin
            wing_nxt[j]  = f[l];
            found_nxt[j] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      wing_r[j] <= wing_nxt[j];
    end
    found_r <= found_nxt;
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.queried_face    <= qidx_r;
      out_r.wing_zero       <= FIELD_VERTEX_BITS'(wing_r[0]);
      out_r.wing_zero_found <= found_r[0];
      out_r.wing_one        <= FIELD_VERTEX_BITS'(wing_r[1]);
      out_r.wing_one_found  <= found_r[1];
      out_r.wing_two        <= FIELD_VERTEX_BITS'(wing_r[2]);
      out_r.wing_two_found  <= found_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- tb/triangle_edge_opposite_vertex_finder_test.sv -----
// ----------------------------------------------------------------------------
// triangle_edge_opposite_vertex_finder_test
// Stores triangle faces and queries their wing vertices. A directed table
// covers reset, extremes and degenerate faces. Random meshes follow, built
// mostly from faces that share reversed edges. Every result word is checked
// field by field against a typed expectation or a predictor that keeps its
// own copy of the face table and of face_count.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_edge_opposite_vertex_finder_test;
  import teovf_pkg::*;

  localparam int NUM_FACES    = 1024;
  localparam int RANDOM_ITEMS = 560;
  localparam int STORE_SETTLE = 8;
  localparam int TAIL_CYCLES  = 1100;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;

  typedef enum logic {ROW_WORD, ROW_COUNT} row_kind_t;

  typedef struct {
    row_kind_t kind;
    in_word_t  w;
    cfg_word_t count;
    bit        typed;
    out_word_t want;
  } row_t;

  logic clk;
  logic rst_n;

  teovf_in_if  in_if ();
  teovf_out_if out_if ();
  teovf_cfg_if cfg_if ();

  triangle_edge_opposite_vertex_finder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Predictor state
  vertex_t   faces [NUM_FACES][3];
  cfg_word_t scan_len;
  out_word_t wings_due [$];

  // Stimulus bookkeeping
  bit      written [NUM_FACES];
  int      stored_ids [$];
  int      filled;
  int      rand_sent;
  vertex_t pool_base;
  logic    steady;
  logic    hold_rx;
  int      faults;
  int      cycles;
  row_t    plan [$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Wing vertices of one face, scanning faces 0 to face_count-1 in order
  function automatic out_word_t predict_wings(face_idx_t f);
    out_word_t r;
    int        n;
    vertex_t   head;
    vertex_t   tail;
    vertex_t   wing;
    logic      found;
    r = '0;
    r.queried_face = f;
    n = (scan_len > NUM_FACES) ? NUM_FACES : int'(scan_len);
    for (int j = 0; j < 3; j++) begin
      head  = faces[f][(j + 1) % 3];
      tail  = faces[f][(j + 2) % 3];
      wing  = '0;
      found = 1'b0;
      for (int k = 0; k < n; k++) begin
        for (int l = 0; l < 3; l++) begin
          // last match in scan order wins
          if (faces[k][(l + 1) % 3] == tail && faces[k][(l + 2) % 3] == head) begin
            wing  = faces[k][l];
            found = 1'b1;
          end
        end
      end
      case (j)
        0: begin
          r.wing_zero       = wing;
          r.wing_zero_found = found;
        end
        1: begin
          r.wing_one       = wing;
          r.wing_one_found = found;
        end
        default: begin
          r.wing_two       = wing;
          r.wing_two_found = found;
        end
      endcase
    end
    return r;
  endfunction

  function automatic row_t mk_row(row_kind_t kind, logic cmd, int idx, int a, int b, int c,
                                  int cnt, bit typed, logic [2:0] found);
    row_t r;
    r.kind         = kind;
    r.w.command    = cmd;
    r.w.face_index = face_idx_t'(idx);
    r.w.vertex_a   = vertex_t'(a);
    r.w.vertex_b   = vertex_t'(b);
    r.w.vertex_c   = vertex_t'(c);
    r.count        = cfg_word_t'(cnt);
    r.typed        = typed;
    r.want         = '0;
    r.want.queried_face    = face_idx_t'(idx);
    r.want.wing_zero_found = found[0];
    r.want.wing_one_found  = found[1];
    r.want.wing_two_found  = found[2];
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(row_t r);
    plan = {plan, r};
  endfunction

  // Vertex near the current pool, now and then anywhere
  function automatic vertex_t fresh_vertex();
    if ($urandom_range(0, 9) == 0) begin
      return vertex_t'($urandom_range(0, 65535));
    end
    return pool_base + vertex_t'($urandom_range(0, 15));
  endfunction

  // Offer one word; record its effect once accepted
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    while (!steady && $urandom_range(0, 99) < 23) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (w.command == CMD_QUERY) begin
      wings_due = {wings_due, (typed ? want : predict_wings(w.face_index))};
    end else begin
      faces[w.face_index][0] = w.vertex_a;
      faces[w.face_index][1] = w.vertex_b;
      faces[w.face_index][2] = w.vertex_c;
      if (!written[w.face_index]) begin
        written[w.face_index] = 1'b1;
        stored_ids = {stored_ids, int'(w.face_index)};
      end
      while (filled < NUM_FACES && written[filled]) filled++;
    end
  endtask

  // Drain, let a last store settle, then write face_count
  task automatic write_count(input cfg_word_t v);
    in_if.valid <= 1'b0;
    while (wings_due.size() != 0) @(posedge clk);
    repeat (STORE_SETTLE) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    scan_len = v;
  endtask

  // Store a face, mostly one that shares a reversed edge with a stored face
  task automatic store_face(input int slot);
    in_word_t w;
    vertex_t  v [3];
    int       k;
    int       l;
    int       r;
    if ($urandom_range(0, 99) < 65) begin
      k    = stored_ids[$urandom_range(0, stored_ids.size() - 1)];
      l    = $urandom_range(0, 2);
      v[0] = fresh_vertex();
      v[1] = faces[k][(l + 2) % 3];
      v[2] = faces[k][(l + 1) % 3];
    end else begin
      v[0] = fresh_vertex();
      v[1] = fresh_vertex();
      v[2] = fresh_vertex();
    end
    r            = $urandom_range(0, 2);
    w.command    = CMD_STORE;
    w.face_index = face_idx_t'(slot);
    w.vertex_a   = v[r];
    w.vertex_b   = v[(r + 1) % 3];
    w.vertex_c   = v[(r + 2) % 3];
    steady <= (rand_sent >= 150 && rand_sent < 260);
    send_word(w, 1'b0, '0);
    rand_sent++;
  endtask

  // Query a written face; the vertex fields carry noise
  task automatic query_face();
    in_word_t w;
    w.command    = CMD_QUERY;
    w.face_index = face_idx_t'(stored_ids[$urandom_range(0, stored_ids.size() - 1)]);
    w.vertex_a   = vertex_t'($urandom_range(0, 65535));
    w.vertex_b   = vertex_t'($urandom_range(0, 65535));
    w.vertex_c   = vertex_t'($urandom_range(0, 65535));
    steady <= (rand_sent >= 150 && rand_sent < 260);
    send_word(w, 1'b0, '0);
    rand_sent++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got, input face_idx_t f);
    if (got !== want) begin
      faults++;
      if (faults <= REPORT_MAX) begin
        $display("face %0d: %s expected %0h, got %0h", f, name, want, got);
      end
    end
  endtask

  // Match a result word against the oldest expectation
  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (wings_due.size() == 0) begin
      faults++;
      if (faults <= REPORT_MAX) begin
        $display("result for face %0d with nothing pending", got.queried_face);
      end
    end else begin
      want = wings_due.pop_front();
      compare_field("queried_face", 16'(want.queried_face), 16'(got.queried_face),
                    want.queried_face);
      compare_field("wing_zero", want.wing_zero, got.wing_zero, want.queried_face);
      compare_field("wing_zero_found", 16'(want.wing_zero_found), 16'(got.wing_zero_found),
                    want.queried_face);
      compare_field("wing_one", want.wing_one, got.wing_one, want.queried_face);
      compare_field("wing_one_found", 16'(want.wing_one_found), 16'(got.wing_one_found),
                    want.queried_face);
      compare_field("wing_two", want.wing_two, got.wing_two, want.queried_face);
      compare_field("wing_two_found", 16'(want.wing_two_found), 16'(got.wing_two_found),
                    want.queried_face);
    end
  endtask

  // Result side: check accepted words, stall at random or during a hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) check_result(out_if.data);
      out_if.ready <= !(hold_rx || (!steady && $urandom_range(0, 99) < 23));
    end
  end

  // Long receiver hold-off while the sender keeps offering words
  initial begin
    hold_rx = 1'b0;
    wait (rand_sent >= 80);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Main stimulus
  initial begin
    int n;
    int m;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    steady       = 1'b0;
    rst_n        = 1'b0;
    scan_len     = '0;
    filled       = 0;
    rand_sent    = 0;
    faults       = 0;
    pool_base    = '0;
    foreach (written[i]) written[i] = 1'b0;

    // Directed rows: a typed expectation where it is obvious
    add_row(mk_row(ROW_WORD, CMD_STORE, 0, 1, 2, 3, 0, 0, 3'b000));
    add_row(mk_row(ROW_WORD, CMD_STORE, 1, 3, 2, 4, 0, 0, 3'b000));
    add_row(mk_row(ROW_WORD, CMD_STORE, 2, 0, 0, 0, 0, 0, 3'b000));
    add_row(mk_row(ROW_WORD, CMD_STORE, 3, 5, 3, 2, 0, 0, 3'b000));
    add_row(mk_row(ROW_WORD, CMD_STORE, 4, 16'hFFFF, 0, 16'hFFFF, 0, 0, 3'b000));
    add_row(mk_row(ROW_WORD, CMD_STORE, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   0, 0, 3'b000));
    // face_count still zero from reset: nothing found
    add_row(mk_row(ROW_WORD, CMD_QUERY, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   0, 1, 3'b000));
    add_row(mk_row(ROW_WORD, CMD_QUERY, 1023, 0, 0, 0, 0, 1, 3'b000));
    add_row(mk_row(ROW_COUNT, CMD_STORE, 0, 0, 0, 0, 2, 0, 3'b000));
    add_row(mk_row(ROW_WORD, CMD_QUERY, 0, 0, 0, 0, 0, 0, 3'b000));
    add_row(mk_row(ROW_WORD, CMD_QUERY, 1, 0, 0, 0, 0, 0, 3'b000));
    // queried face beyond face_count, no neighbor within the scan
    add_row(mk_row(ROW_WORD, CMD_QUERY, 1023, 16'h5555, 16'hAAAA, 0, 0, 1, 3'b000));
    add_row(mk_row(ROW_COUNT, CMD_STORE, 0, 0, 0, 0, 3, 0, 3'b000));
    // all-zero face matches itself on every edge
    add_row(mk_row(ROW_WORD, CMD_QUERY, 2, 0, 0, 0, 0, 1, 3'b111));
    add_row(mk_row(ROW_COUNT, CMD_STORE, 0, 0, 0, 0, 4, 0, 3'b000));
    // two neighbors across one edge: the later face wins
    add_row(mk_row(ROW_WORD, CMD_QUERY, 0, 0, 0, 0, 0, 0, 3'b000));
    add_row(mk_row(ROW_COUNT, CMD_STORE, 0, 0, 0, 0, 5, 0, 3'b000));
    add_row(mk_row(ROW_WORD, CMD_QUERY, 1023, 0, 0, 0, 0, 0, 3'b000));
    add_row(mk_row(ROW_WORD, CMD_QUERY, 4, 0, 0, 0, 0, 0, 3'b000));
    add_row(mk_row(ROW_WORD, CMD_STORE, 0, 16'hAAAA, 16'h5555, 16'h1234,
                   0, 0, 3'b000));
    add_row(mk_row(ROW_WORD, CMD_QUERY, 0, 0, 0, 0, 0, 0, 3'b000));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_COUNT) begin
        write_count(plan[i].count);
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].want);
      end
    end

    // Random meshes: grow the written prefix, set face_count, mix stores and queries
    while (rand_sent < RANDOM_ITEMS) begin
      m = $urandom_range(0, 99);
      n = (m < 10) ? 0 : (m < 90) ? $urandom_range(1, 48) : $urandom_range(49, 120);
      pool_base = vertex_t'($urandom_range(0, 65535));
      while (filled < n) store_face(filled);
      write_count(cfg_word_t'(n));
      m = $urandom_range(4, 24);
      repeat (m) begin
        if ($urandom_range(0, 99) < 35) begin
          case ($urandom_range(0, 3))
            0:       store_face(filled < NUM_FACES ? filled : 0);
            1:       store_face($urandom_range(0, NUM_FACES - 1));
            default: store_face(stored_ids[$urandom_range(0, stored_ids.size() - 1)]);
          endcase
        end else begin
          query_face();
        end
      end
    end

    // Drain and watch for stray words
    in_if.valid <= 1'b0;
    while (wings_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (faults == 0 && wings_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/teovf_pkg.sv
hw/rtl/teovf_if.sv
hw/rtl/teovf_ram.sv
hw/rtl/teovf_ctrl.sv
hw/rtl/teovf_dp.sv
hw/rtl/triangle_edge_opposite_vertex_finder.sv
tb/triangle_edge_opposite_vertex_finder_test.sv
